>>> src/cfpu_pkg.sv
package cfpu_pkg;

   // Frame size and index width (qubit fields are 6 bits wide)
   localparam int MAX_QUBITS = 64;
   localparam int QIDX_W     = 6;
   localparam int LIMIT_W    = 7;

   // Request modes
   localparam logic [3:0] MODE_CLEAR  = 4'd0;
   localparam logic [3:0] MODE_FACTOR = 4'd1;
   localparam logic [3:0] MODE_READ   = 4'd2;
   localparam logic [3:0] MODE_X      = 4'd3;
   localparam logic [3:0] MODE_Y      = 4'd4;
   localparam logic [3:0] MODE_Z      = 4'd5;
   localparam logic [3:0] MODE_H      = 4'd6;
   localparam logic [3:0] MODE_S      = 4'd7;
   localparam logic [3:0] MODE_SDG    = 4'd8;
   localparam logic [3:0] MODE_CNOT   = 4'd9;
   localparam logic [3:0] MODE_CZ     = 4'd10;
   localparam logic [3:0] MODE_SWAP   = 4'd11;

   // Error codes
   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_RANGE = 2'd1;
   localparam logic [1:0] ERR_SAME  = 2'd2;

   // Pauli axes
   localparam logic [1:0] AXIS_I = 2'd0;
   localparam logic [1:0] AXIS_X = 2'd1;
   localparam logic [1:0] AXIS_Y = 2'd2;
   localparam logic [1:0] AXIS_Z = 2'd3;

   // Phase steps as powers of i
   localparam logic [1:0] PH_ONE   = 2'd0;
   localparam logic [1:0] PH_I     = 2'd1;
   localparam logic [1:0] PH_NEG   = 2'd2;
   localparam logic [1:0] PH_NEG_I = 2'd3;

   typedef struct packed {
      logic [3:0]        mode;
      logic [QIDX_W-1:0] first_qubit;
      logic [QIDX_W-1:0] second_qubit;
      logic [1:0]        factor_axis;
   } cfpu_req_type;

   typedef struct packed {
      logic [1:0] phase_power;
      logic [1:0] axis_first;
      logic [1:0] axis_second;
      logic [1:0] error_code;
   } cfpu_rsp_type;

   // Frame write command from the update logic
   typedef struct packed {
      logic              clear;
      logic              wr_first;
      logic [QIDX_W-1:0] first_addr;
      logic [1:0]        first_wdata;
      logic              wr_second;
      logic [QIDX_W-1:0] second_addr;
      logic [1:0]        second_wdata;
      logic              wr_phase;
      logic [1:0]        phase;
   } cfpu_wr_type;

   // Axis plus phase step
   typedef struct packed {
      logic [1:0] axis;
      logic [1:0] ph;
   } cfpu_term_type;

   typedef struct packed {
      logic [1:0] axis_first;
      logic [1:0] axis_second;
      logic [1:0] ph;
   } cfpu_pair_type;

   // Right-multiply axis a by b
   function automatic cfpu_term_type mul_axes(input logic [1:0] a, input logic [1:0] b);
      cfpu_term_type r;
      logic [1:0]    next_a;
      next_a = (a == AXIS_Z) ? AXIS_X : a + 2'd1;
      if (a == AXIS_I) begin
         r = '{axis: b, ph: PH_ONE};
      end else if (b == AXIS_I) begin
         r = '{axis: a, ph: PH_ONE};
      end else if (a == b) begin
         r = '{axis: AXIS_I, ph: PH_ONE};
      end else begin
         r.axis = a ^ b;
         r.ph   = (b == next_a) ? PH_I : PH_NEG_I;
      end
      return r;
   endfunction

   // Backward conjugation of one axis through a single-qubit gate
   function automatic cfpu_term_type one_gate(input logic [3:0] mode, input logic [1:0] a);
      cfpu_term_type r;
      r = '{axis: a, ph: PH_ONE};
      case (mode)
         MODE_X: begin
            if (a == AXIS_Y || a == AXIS_Z) r.ph = PH_NEG;
         end
         MODE_Y: begin
            if (a == AXIS_X || a == AXIS_Z) r.ph = PH_NEG;
         end
         MODE_Z: begin
            if (a == AXIS_X || a == AXIS_Y) r.ph = PH_NEG;
         end
         MODE_H: begin
            if (a == AXIS_X) r.axis = AXIS_Z;
            if (a == AXIS_Z) r.axis = AXIS_X;
            if (a == AXIS_Y) r.ph = PH_NEG;
         end
         MODE_S: begin
            if (a == AXIS_X) r = '{axis: AXIS_Y, ph: PH_NEG};
            if (a == AXIS_Y) r.axis = AXIS_X;
         end
         MODE_SDG: begin
            if (a == AXIS_X) r.axis = AXIS_Y;
            if (a == AXIS_Y) r = '{axis: AXIS_X, ph: PH_NEG};
         end
         default: r = '{axis: a, ph: PH_ONE};
      endcase
      return r;
   endfunction

   // Image of generator zx (0 X, 1 Z) on source qubit src: {first, second}
   function automatic logic [3:0] pair_gen(input logic [3:0] mode, input logic src,
                                           input logic zx);
      logic [3:0] r;
      r = {AXIS_I, AXIS_I};
      case (mode)
         MODE_CNOT: begin
            case ({src, zx})
               2'b00:   r = {AXIS_X, AXIS_X};
               2'b01:   r = {AXIS_Z, AXIS_I};
               2'b10:   r = {AXIS_I, AXIS_X};
               default: r = {AXIS_Z, AXIS_Z};
            endcase
         end
         MODE_CZ: begin
            case ({src, zx})
               2'b00:   r = {AXIS_X, AXIS_Z};
               2'b01:   r = {AXIS_Z, AXIS_I};
               2'b10:   r = {AXIS_Z, AXIS_X};
               default: r = {AXIS_I, AXIS_Z};
            endcase
         end
         MODE_SWAP: begin
            case ({src, zx})
               2'b00:   r = {AXIS_I, AXIS_X};
               2'b01:   r = {AXIS_I, AXIS_Z};
               2'b10:   r = {AXIS_X, AXIS_I};
               default: r = {AXIS_Z, AXIS_I};
            endcase
         end
         default: r = {AXIS_I, AXIS_I};
      endcase
      return r;
   endfunction

   // Backward conjugation of two axes through a two-qubit gate
   function automatic cfpu_pair_type pair_map(input logic [3:0] mode, input logic [1:0] a0,
                                              input logic [1:0] a1);
      cfpu_pair_type r;
      cfpu_term_type t;
      logic [1:0]    a;
      logic [3:0]    g;
      logic          want;
      r = '{axis_first: AXIS_I, axis_second: AXIS_I, ph: PH_ONE};
      // Y = i X Z; walk X then Z of each source qubit
      for (int s = 0; s < 2; s++) begin
         a = (s == 0) ? a0 : a1;
         if (a == AXIS_Y) r.ph = r.ph + PH_I;
         for (int k = 0; k < 2; k++) begin
            want = (k == 0) ? (a == AXIS_X || a == AXIS_Y) : (a == AXIS_Z || a == AXIS_Y);
            g    = pair_gen(mode, s[0], k[0]);
            if (want) begin
               t            = mul_axes(r.axis_first, g[3:2]);
               r.axis_first = t.axis;
               r.ph         = r.ph + t.ph;
               t             = mul_axes(r.axis_second, g[1:0]);
               r.axis_second = t.axis;
               r.ph          = r.ph + t.ph;
            end
         end
      end
      return r;
   endfunction

endpackage

>>> src/cfpu_frame.sv
module cfpu_frame (
   input  logic                          clock,
   input  logic                          reset,
   input  cfpu_pkg::cfpu_wr_type         wr,
   input  logic [cfpu_pkg::QIDX_W-1:0]   rd_first_addr,
   input  logic [cfpu_pkg::QIDX_W-1:0]   rd_second_addr,
   output logic [1:0]                    rd_first_axis,
   output logic [1:0]                    rd_second_axis,
   output logic [1:0]                    phase
);
   import cfpu_pkg::*;

   logic [1:0]            axis_mem [MAX_QUBITS];
   logic [MAX_QUBITS-1:0] valid_ff;
   logic [MAX_QUBITS-1:0] valid_in;
   logic [1:0]            rd_first_ff;
   logic [1:0]            rd_second_ff;
   logic [1:0]            phase_ff;

   // Axis store; entries without a valid bit read as identity
   always_ff @(posedge clock) begin
      if (wr.wr_first) axis_mem[wr.first_addr] <= wr.first_wdata;
      if (wr.wr_second) axis_mem[wr.second_addr] <= wr.second_wdata;
   end

   // Mark written entries; clear drops the whole string to identity
   always_comb begin
      valid_in = valid_ff;
      if (wr.wr_first) valid_in[wr.first_addr] = 1'b1;
      if (wr.wr_second) valid_in[wr.second_addr] = 1'b1;
      if (wr.clear) valid_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Register both reads, passing through a write at the same edge
   always_ff @(posedge clock) begin
      if (reset || wr.clear) begin
         rd_first_ff  <= AXIS_I;
         rd_second_ff <= AXIS_I;
      end else begin
         if (wr.wr_first && wr.first_addr == rd_first_addr) begin
            rd_first_ff <= wr.first_wdata;
         end else if (wr.wr_second && wr.second_addr == rd_first_addr) begin
            rd_first_ff <= wr.second_wdata;
         end else if (!valid_ff[rd_first_addr]) begin
            rd_first_ff <= AXIS_I;
         end else begin
            rd_first_ff <= axis_mem[rd_first_addr];
         end
         if (wr.wr_first && wr.first_addr == rd_second_addr) begin
            rd_second_ff <= wr.first_wdata;
         end else if (wr.wr_second && wr.second_addr == rd_second_addr) begin
            rd_second_ff <= wr.second_wdata;
         end else if (!valid_ff[rd_second_addr]) begin
            rd_second_ff <= AXIS_I;
         end else begin
            rd_second_ff <= axis_mem[rd_second_addr];
         end
      end
   end

   // Global phase power
   always_ff @(posedge clock) begin
      if (reset || wr.clear) begin
         phase_ff <= PH_ONE;
      end else if (wr.wr_phase) begin
         phase_ff <= wr.phase;
      end
   end

   assign rd_first_axis  = rd_first_ff;
   assign rd_second_axis = rd_second_ff;
   assign phase          = phase_ff;

endmodule

>>> src/cfpu_update.sv
module cfpu_update (
   input  logic                          commit,
   input  cfpu_pkg::cfpu_req_type        req,
   input  logic [cfpu_pkg::LIMIT_W-1:0]  active_qubits,
   input  logic [1:0]                    old_first,
   input  logic [1:0]                    old_second,
   input  logic [1:0]                    old_phase,
   output cfpu_pkg::cfpu_wr_type         wr,
   output cfpu_pkg::cfpu_rsp_type        rsp
);
   import cfpu_pkg::*;

   logic [LIMIT_W-1:0] limit;
   logic               in_first;
   logic               in_second;
   logic               clear;
   logic               upd_first;
   logic               upd_second;
   logic [1:0]         new_first;
   logic [1:0]         new_second;
   logic [1:0]         dph;
   logic [1:0]         err;
   cfpu_term_type      term;
   cfpu_pair_type      pair;

   // Range check against min(active_qubits, MAX_QUBITS)
   assign limit     = (active_qubits > LIMIT_W'(MAX_QUBITS)) ? LIMIT_W'(MAX_QUBITS)
                                                             : active_qubits;
   assign in_first  = {1'b0, req.first_qubit} < limit;
   assign in_second = {1'b0, req.second_qubit} < limit;

   // Decode the request and form the new axes and phase step
   always_comb begin
      clear      = 1'b0;
      upd_first  = 1'b0;
      upd_second = 1'b0;
      new_first  = old_first;
      new_second = old_second;
      dph        = PH_ONE;
      err        = ERR_OK;
      term       = mul_axes(old_first, req.factor_axis);
      pair       = pair_map(req.mode, old_first, old_second);
      case (req.mode)
         MODE_CLEAR: begin
            clear = 1'b1;
         end
         MODE_FACTOR: begin
            if (!in_first) begin
               err = ERR_RANGE;
            end else begin
               upd_first = 1'b1;
               new_first = term.axis;
               dph       = term.ph;
            end
         end
         MODE_READ: begin
            if (!in_first) err = ERR_RANGE;
         end
         MODE_X, MODE_Y, MODE_Z, MODE_H, MODE_S, MODE_SDG: begin
            term = one_gate(req.mode, old_first);
            if (!in_first) begin
               err = ERR_RANGE;
            end else begin
               upd_first = 1'b1;
               new_first = term.axis;
               dph       = term.ph;
            end
         end
         MODE_CNOT, MODE_CZ, MODE_SWAP: begin
            if (!in_first || !in_second) begin
               err = ERR_RANGE;
            end else if (req.first_qubit == req.second_qubit) begin
               err = ERR_SAME;
            end else begin
               upd_first  = 1'b1;
               upd_second = 1'b1;
               new_first  = pair.axis_first;
               new_second = pair.axis_second;
               dph        = pair.ph;
            end
         end
         default: begin
            err = ERR_OK;
         end
      endcase
   end

   // Gate the frame writes with the pipeline advance
   always_comb begin
      wr.clear        = commit && clear;
      wr.wr_first     = commit && upd_first;
      wr.first_addr   = req.first_qubit;
      wr.first_wdata  = new_first;
      wr.wr_second    = commit && upd_second;
      wr.second_addr  = req.second_qubit;
      wr.second_wdata = new_second;
      wr.wr_phase     = commit && upd_first;
      wr.phase        = old_phase + dph;
   end

   // Result reflects the state after the step
   always_comb begin
      rsp.error_code  = err;
      rsp.phase_power = clear ? PH_ONE : (old_phase + dph);
      if (!in_first || clear) begin
         rsp.axis_first = AXIS_I;
      end else begin
         rsp.axis_first = upd_first ? new_first : old_first;
      end
      if (!in_second || clear) begin
         rsp.axis_second = AXIS_I;
      end else if (upd_second) begin
         rsp.axis_second = new_second;
      end else if (upd_first && req.second_qubit == req.first_qubit) begin
         rsp.axis_second = new_first;
      end else begin
         rsp.axis_second = old_second;
      end
   end

endmodule

>>> src/clifford_pauli_frame_update.sv
// Pauli frame tracker: one Pauli string, updated by one request per cycle.
// A request's frame entries are read as it is taken into the input register;
// its response is registered once the response register has room.
// Throughput: one request per cycle while rsp_ready keeps the output moving.
// Reset: frame cleared to identity, phase zero, active_qubits 64, no response.
module clifford_pauli_frame_update (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  cfpu_pkg::cfpu_req_type        req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output cfpu_pkg::cfpu_rsp_type        rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cfpu_pkg::LIMIT_W-1:0]  csr_data
);
   import cfpu_pkg::*;

   cfpu_req_type       req_ff;
   cfpu_req_type       req_in;
   logic               req_valid_ff;
   logic               req_valid_in;
   cfpu_rsp_type       rsp_ff;
   cfpu_rsp_type       rsp_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [LIMIT_W-1:0] active_ff;
   logic [LIMIT_W-1:0] active_in;
   logic               advance;
   logic               take;
   logic [1:0]         old_first;
   logic [1:0]         old_second;
   logic [1:0]         old_phase;
   cfpu_wr_type        wr;
   cfpu_rsp_type       result;

   // Move the held request into the response register when it has room
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign take      = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign req_in       = take ? req_data : req_ff;
   assign req_valid_in = take || (req_valid_ff && !advance);
   assign rsp_in       = advance ? result : rsp_ff;
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   assign active_in    = (csr_valid && csr_ready) ? csr_data : active_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         active_ff    <= LIMIT_W'(MAX_QUBITS);
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   // Read the frame at the request entering the input register
   cfpu_frame u_frame (
      .clock          (clock),
      .reset          (reset),
      .wr             (wr),
      .rd_first_addr  (req_in.first_qubit),
      .rd_second_addr (req_in.second_qubit),
      .rd_first_axis  (old_first),
      .rd_second_axis (old_second),
      .phase          (old_phase)
   );

   cfpu_update u_update (
      .commit        (advance),
      .req           (req_ff),
      .active_qubits (active_ff),
      .old_first     (old_first),
      .old_second    (old_second),
      .old_phase     (old_phase),
      .wr            (wr),
      .rsp           (result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> tb/clifford_pauli_frame_update_tb.sv
module clifford_pauli_frame_update_tb;
   import cfpu_pkg::*;

   localparam int         STALL_LIMIT = 2000;
   localparam int         LONG_HOLD   = 300;
   localparam logic [3:0] MODE_LAST   = 4'hF;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   cfpu_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   cfpu_rsp_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [6:0]   csr_data = 7'd64;

   // Predicted frame: one axis per qubit, global phase, qubit limit
   logic [1:0]   frame_axis [0:MAX_QUBITS-1];
   logic [1:0]   frame_phase;
   logic [6:0]   qubit_limit;
   cfpu_rsp_type frame_rsp_q [$];

   int  requests_sent  = 0;
   int  responses_seen = 0;
   int  mismatch_count = 0;
   int  limit_writes   = 0;
   int  quiet_cycles   = 0;
   int  rsp_hold       = 0;
   bit  req_idle       = 1'b1;
   bit  rsp_idle       = 1'b1;

   clifford_pauli_frame_update dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Right product a*b of two Pauli axes: {axis, phase step}
   function automatic logic [3:0] pauli_product(input logic [1:0] a, input logic [1:0] b);
      logic cyclic;
      if (a == AXIS_I) return {b, PH_ONE};
      if (b == AXIS_I) return {a, PH_ONE};
      if (a == b) return {AXIS_I, PH_ONE};
      cyclic = (a == AXIS_X && b == AXIS_Y) || (a == AXIS_Y && b == AXIS_Z) ||
               (a == AXIS_Z && b == AXIS_X);
      return {a ^ b, cyclic ? PH_I : PH_NEG_I};
   endfunction

   // Single-qubit gate pulled back through one axis: {axis, phase step}
   function automatic logic [3:0] conjugate_one(input logic [3:0] mode, input logic [1:0] a);
      logic [1:0] gate_axis;
      if (a == AXIS_I) return {AXIS_I, PH_ONE};
      case (mode)
         MODE_X, MODE_Y, MODE_Z: begin
            gate_axis = (mode == MODE_X) ? AXIS_X : (mode == MODE_Y) ? AXIS_Y : AXIS_Z;
            return {a, (a == gate_axis) ? PH_ONE : PH_NEG};
         end
         MODE_H: begin
            if (a == AXIS_X) return {AXIS_Z, PH_ONE};
            if (a == AXIS_Z) return {AXIS_X, PH_ONE};
            return {AXIS_Y, PH_NEG};
         end
         MODE_S: begin
            if (a == AXIS_X) return {AXIS_Y, PH_NEG};
            if (a == AXIS_Y) return {AXIS_X, PH_ONE};
            return {a, PH_ONE};
         end
         MODE_SDG: begin
            if (a == AXIS_X) return {AXIS_Y, PH_ONE};
            if (a == AXIS_Y) return {AXIS_X, PH_NEG};
            return {a, PH_ONE};
         end
         default: return {a, PH_ONE};
      endcase
   endfunction

   // Image of an X (z_gen 0) or Z (z_gen 1) generator on one side: {first, second}
   function automatic logic [3:0] generator_image(input logic [3:0] mode, input bit on_second,
                                                  input bit z_gen);
      case (mode)
         MODE_CNOT:
            if (!on_second) return z_gen ? {AXIS_Z, AXIS_I} : {AXIS_X, AXIS_X};
            else            return z_gen ? {AXIS_Z, AXIS_Z} : {AXIS_I, AXIS_X};
         MODE_CZ:
            if (!on_second) return z_gen ? {AXIS_Z, AXIS_I} : {AXIS_X, AXIS_Z};
            else            return z_gen ? {AXIS_I, AXIS_Z} : {AXIS_Z, AXIS_X};
         default:
            if (!on_second) return z_gen ? {AXIS_I, AXIS_Z} : {AXIS_I, AXIS_X};
            else            return z_gen ? {AXIS_Z, AXIS_I} : {AXIS_X, AXIS_I};
      endcase
   endfunction

   // Two-qubit gate pulled back: Y = i X Z, multiply generator images in order
   function automatic logic [5:0] conjugate_pair(input logic [3:0] mode, input logic [1:0] a0,
                                                 input logic [1:0] a1);
      logic [1:0] new_first, new_second, ph, a;
      logic [3:0] img, t;
      bit         has_gen;
      new_first  = AXIS_I;
      new_second = AXIS_I;
      ph         = PH_ONE;
      for (int s = 0; s < 2; s++) begin
         a = s ? a1 : a0;
         if (a == AXIS_Y) ph = ph + PH_I;
         for (int g = 0; g < 2; g++) begin
            has_gen = g ? (a == AXIS_Z || a == AXIS_Y) : (a == AXIS_X || a == AXIS_Y);
            if (has_gen) begin
               img        = generator_image(mode, s[0], g[0]);
               t          = pauli_product(new_first, img[3:2]);
               new_first  = t[3:2];
               ph         = ph + t[1:0];
               t          = pauli_product(new_second, img[1:0]);
               new_second = t[3:2];
               ph         = ph + t[1:0];
            end
         end
      end
      return {new_first, new_second, ph};
   endfunction

   // Advance the predicted frame by one request and return the expected response
   function automatic cfpu_rsp_type apply_frame_request(input cfpu_req_type r);
      cfpu_rsp_type o;
      logic [3:0]   t;
      logic [5:0]   p;
      int           lim;
      bit           out1, out2;
      lim  = (qubit_limit < MAX_QUBITS) ? qubit_limit : MAX_QUBITS;
      out1 = r.first_qubit >= lim;
      out2 = r.second_qubit >= lim;
      o.error_code = ERR_OK;
      case (r.mode)
         MODE_CLEAR: begin
            foreach (frame_axis[i]) frame_axis[i] = AXIS_I;
            frame_phase = PH_ONE;
         end
         MODE_FACTOR, MODE_READ, MODE_X, MODE_Y, MODE_Z, MODE_H, MODE_S, MODE_SDG: begin
            if (out1) begin
               o.error_code = ERR_RANGE;
            end else if (r.mode != MODE_READ) begin
               if (r.mode == MODE_FACTOR)
                  t = pauli_product(frame_axis[r.first_qubit], r.factor_axis);
               else
                  t = conjugate_one(r.mode, frame_axis[r.first_qubit]);
               frame_axis[r.first_qubit] = t[3:2];
               frame_phase = frame_phase + t[1:0];
            end
         end
         MODE_CNOT, MODE_CZ, MODE_SWAP: begin
            if (out1 || out2) begin
               o.error_code = ERR_RANGE;
            end else if (r.first_qubit == r.second_qubit) begin
               o.error_code = ERR_SAME;
            end else begin
               p = conjugate_pair(r.mode, frame_axis[r.first_qubit],
                                  frame_axis[r.second_qubit]);
               frame_axis[r.first_qubit]  = p[5:4];
               frame_axis[r.second_qubit] = p[3:2];
               frame_phase = frame_phase + p[1:0];
            end
         end
         default: ;
      endcase
      o.phase_power = frame_phase;
      o.axis_first  = out1 ? AXIS_I : frame_axis[r.first_qubit];
      o.axis_second = out2 ? AXIS_I : frame_axis[r.second_qubit];
      return o;
   endfunction

   // Track configuration, predict accepted requests, check each response
   always @(posedge clock) begin : scoreboard
      cfpu_rsp_type want;
      if (reset) begin
         foreach (frame_axis[i]) frame_axis[i] = AXIS_I;
         frame_phase = PH_ONE;
         qubit_limit = 7'd64;
      end else begin
         if (csr_valid && csr_ready) qubit_limit = csr_data;
         if (req_valid && req_ready)
            frame_rsp_q.insert(frame_rsp_q.size(), apply_frame_request(req_data));
         if (rsp_valid && rsp_ready) begin
            responses_seen++;
            if (frame_rsp_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response: phase %0d first %0d second %0d err %0d",
                           rsp_data.phase_power, rsp_data.axis_first,
                           rsp_data.axis_second, rsp_data.error_code);
            end else begin
               want = frame_rsp_q.pop_front();
               if (rsp_data.phase_power !== want.phase_power ||
                   rsp_data.axis_first  !== want.axis_first  ||
                   rsp_data.axis_second !== want.axis_second ||
                   rsp_data.error_code  !== want.error_code) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("mismatch at response %0d: expected phase %0d first %0d",
                              responses_seen, want.phase_power, want.axis_first);
                     $display("   second %0d err %0d, got phase %0d first %0d",
                              want.axis_second, want.error_code,
                              rsp_data.phase_power, rsp_data.axis_first);
                     $display("   second %0d err %0d",
                              rsp_data.axis_second, rsp_data.error_code);
                  end
               end
            end
         end
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", quiet_cycles);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Response side: random stall per response, or a long hold on request
   initial begin : response_side
      int n;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold > 0) begin
            n = rsp_hold;
            rsp_hold = 0;
         end else begin
            n = rsp_idle ? $urandom_range(0, 19) : 0;
         end
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   function automatic cfpu_req_type make_request(input logic [3:0] mode,
                                                 input logic [5:0] q1, input logic [5:0] q2,
                                                 input logic [1:0] fax);
      cfpu_req_type r;
      r.mode         = mode;
      r.first_qubit  = q1;
      r.second_qubit = q2;
      r.factor_axis  = fax;
      return r;
   endfunction

   // Mostly legal gates on active qubits, with some clears, spare modes and bad indexes
   function automatic cfpu_req_type random_request();
      int         lim, pick;
      logic [3:0] mode;
      logic [5:0] q1, q2;
      lim  = (qubit_limit < MAX_QUBITS) ? qubit_limit : MAX_QUBITS;
      pick = $urandom_range(0, 99);
      if (pick < 2)       mode = MODE_CLEAR;
      else if (pick < 5)  mode = 4'($urandom_range(MODE_SWAP + 1, MODE_LAST));
      else if (pick < 10) mode = MODE_READ;
      else if (pick < 30) mode = MODE_FACTOR;
      else if (pick < 60) mode = 4'($urandom_range(MODE_X, MODE_SDG));
      else                mode = 4'($urandom_range(MODE_CNOT, MODE_SWAP));
      q1 = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                       : 6'($urandom_range(0, lim - 1));
      q2 = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                       : 6'($urandom_range(0, lim - 1));
      if ($urandom_range(0, 29) == 0) q2 = q1;
      return make_request(mode, q1, q2, 2'($urandom_range(0, 3)));
   endfunction

   // Offer one request after a random gap; return at the edge it is taken
   task automatic send_request(input cfpu_req_type r);
      int gap;
      gap = req_idle ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
   endtask

   // Drop valid and hold until every predicted response has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (responses_seen != requests_sent) @(posedge clock);
   endtask

   task automatic set_qubit_limit(input logic [6:0] value);
      wait_drained();
      repeat (2) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      limit_writes++;
   endtask

   task automatic test_single_qubit();
      send_request(make_request(MODE_CLEAR, 6'd0, 6'd63, AXIS_I));
      send_request(make_request(MODE_FACTOR, 6'd0, 6'd0, AXIS_X));
      send_request(make_request(MODE_FACTOR, 6'd0, 6'd0, AXIS_Y));
      // multiply by identity leaves the frame alone
      send_request(make_request(MODE_FACTOR, 6'd0, 6'd0, AXIS_I));
      send_request(make_request(MODE_FACTOR, 6'd63, 6'd0, AXIS_Z));
      for (int m = MODE_X; m <= MODE_SDG; m++)
         send_request(make_request(m[3:0], 6'd0, 6'd63, AXIS_I));
      send_request(make_request(MODE_READ, 6'd63, 6'd0, AXIS_Z));
   endtask

   task automatic test_two_qubit();
      send_request(make_request(MODE_FACTOR, 6'd1, 6'd0, AXIS_Y));
      send_request(make_request(MODE_CNOT, 6'd1, 6'd63, AXIS_I));
      send_request(make_request(MODE_CZ, 6'd63, 6'd1, AXIS_I));
      send_request(make_request(MODE_SWAP, 6'd1, 6'd0, AXIS_I));
      // same qubit on both sides
      send_request(make_request(MODE_CNOT, 6'd5, 6'd5, AXIS_X));
      // spare modes act as a read
      for (int m = MODE_SWAP + 1; m <= MODE_LAST; m++)
         send_request(make_request(m[3:0], 6'd63, 6'd63, AXIS_Z));
   endtask

   task automatic test_qubit_range();
      set_qubit_limit(7'd1);
      send_request(make_request(MODE_FACTOR, 6'd1, 6'd0, AXIS_X));
      send_request(make_request(MODE_CNOT, 6'd0, 6'd1, AXIS_I));
      send_request(make_request(MODE_X, 6'd0, 6'd63, AXIS_I));
      send_request(make_request(MODE_CLEAR, 6'd63, 6'd63, AXIS_Z));
      set_qubit_limit(7'd64);
   endtask

   task automatic test_random_frame(input int count, input bit idle);
      req_idle = idle;
      rsp_idle = idle;
      repeat (count) send_request(random_request());
   endtask

   // Hold the response side for a long stretch while requests keep coming
   task automatic test_backpressure();
      wait_drained();
      rsp_hold = LONG_HOLD;
      req_idle = 1'b0;
      repeat (60) send_request(random_request());
      req_idle = 1'b1;
   endtask

   // Pause the request side until the frame has answered everything
   task automatic test_sender_pause();
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      repeat (5) begin
         repeat (10) send_request(random_request());
         wait_drained();
      end
   endtask

   task automatic test_limit_sweep();
      set_qubit_limit(7'd8);
      test_random_frame(400, 1'b1);
      set_qubit_limit(7'd2);
      test_random_frame(150, 1'b1);
      set_qubit_limit(7'd1);
      test_random_frame(80, 1'b1);
      repeat (4) begin
         set_qubit_limit(7'($urandom_range(1, 64)));
         test_random_frame(80, 1'($urandom_range(0, 1)));
      end
      set_qubit_limit(7'd64);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_single_qubit();
      test_two_qubit();
      test_qubit_range();
      test_random_frame(500, 1'b1);
      test_random_frame(300, 1'b0);
      test_backpressure();
      test_sender_pause();
      test_limit_sweep();
      wait_drained();
      repeat (4) @(posedge clock);
      mismatch_count += frame_rsp_q.size();
      $display("Checked %0d responses to %0d requests over %0d qubit-limit writes",
               responses_seen, requests_sent, limit_writes);
      $display("Mismatched or missing responses: %0d", mismatch_count);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

>>> filelist.f
src/cfpu_pkg.sv
src/cfpu_frame.sv
src/cfpu_update.sv
src/clifford_pauli_frame_update.sv
tb/clifford_pauli_frame_update_tb.sv
